// File: rtl/core/assert_macros.svh
// Assertion macros shared by the queue and back-end modules of the ray marcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/core/rmco_pkg.sv
// Shared types, constants and elaboration-time direction math of the ray marcher.
`timescale 1ns / 1ps
`default_nettype none

package rmco_pkg;

	localparam int COORD_W   = 12;
	localparam int RAD_W     = 11;
	localparam int IDX_W     = 7;
	localparam int REG_IDX_W = 3;
	localparam int MQ_DEPTH  = 2;
	localparam int OQ_DEPTH  = 4;

	localparam logic [COORD_W-1:0] LIGHT_X_RST  = 12'd500;
	localparam logic [COORD_W-1:0] LIGHT_Y_RST  = 12'd200;
	localparam logic [COORD_W-1:0] OBS_X_RST    = 12'd300;
	localparam logic [COORD_W-1:0] OBS_Y_RST    = 12'd300;
	localparam logic [RAD_W-1:0]   OBS_R_RST    = 11'd75;
	localparam logic [COORD_W-1:0] SCREEN_W_RST = 12'd1200;
	localparam logic [COORD_W-1:0] SCREEN_H_RST = 12'd900;

	localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;
	localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LIGHT_X  = 3'd0,
		REG_LIGHT_Y  = 3'd1,
		REG_OBS_X    = 3'd2,
		REG_OBS_Y    = 3'd3,
		REG_OBS_R    = 3'd4,
		REG_SCREEN_W = 3'd5,
		REG_SCREEN_H = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] light_x;
		logic [COORD_W-1:0] light_y;
		logic [COORD_W-1:0] obstacle_x;
		logic [COORD_W-1:0] obstacle_y;
		logic [RAD_W-1:0]   obstacle_radius;
		logic [COORD_W-1:0] screen_width;
		logic [COORD_W-1:0] screen_height;
	} cfg_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [IDX_W-1:0]   ray_index;
		logic [COORD_W-1:0] light_x;
		logic [COORD_W-1:0] light_y;
	} mq_entry_t;

	typedef struct packed {
		logic               pixel_valid;
		logic [COORD_W-1:0] x_pixel;
		logic [COORD_W-1:0] y_pixel;
		logic               ray_done;
		logic               hit_obstacle;
	} result_t;

	// Restoring long division, quotient in the upper half and remainder in the lower half.
	function automatic logic [127:0] udivmod(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return {quo, rem[63:0]};
	endfunction

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Taylor series of cos or sin for an angle of at most pi/4, Q60 in and out.
	function automatic logic [63:0] series_q60(input logic [63:0] x, input logic want_sin);
		logic [63:0]  x2;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [63:0]  dv;
		logic [127:0] qr;
		x2   = mul_q60(x, x);
		term = want_sin ? x : ONE_Q60;
		sum  = term;
		for (int k = 2; k < 64 && term != 64'd0; k += 2) begin
			dv   = want_sin ? 64'(k * (k + 1)) : 64'((k - 1) * k);
			qr   = udivmod(mul_q60(term, x2), dv);
			term = qr[127:64];
			if (k[1])
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum;
	endfunction

	// Round a Q60 value to frac fraction bits, half away from zero.
	function automatic logic [63:0] round_frac(input logic [63:0] v, input int frac);
		logic [63:0] m;
		logic [63:0] r;
		m = v[63] ? (64'd0 - v) : v;
		r = (m + (64'd1 << (60 - frac - 1))) >> (60 - frac);
		return v[63] ? (64'd0 - r) : r;
	endfunction

	// Unit direction of a ray index as {dir_x, dir_y}, each a 64-bit two's complement value.
	function automatic logic [127:0] ray_dir(input int rays, input int frac, input int index);
		logic [127:0] qr;
		logic [63:0]  idx;
		logic [63:0]  quad;
		logic [63:0]  n;
		logic [63:0]  an;
		logic [63:0]  q;
		logic [63:0]  rm;
		logic [63:0]  r;
		logic [63:0]  c;
		logic [63:0]  s;
		logic [63:0]  cx;
		logic [63:0]  sy;
		qr   = udivmod(64'(index), 64'(rays));
		idx  = qr[63:0];
		qr   = udivmod((idx << 3) + 64'(rays), 64'(2 * rays));
		quad = qr[127:64];
		n    = (idx << 2) - quad * 64'(rays);
		an   = n[63] ? (64'd0 - n) : n;
		qr   = udivmod(HALF_PI_Q60, 64'(rays));
		q    = qr[127:64];
		rm   = qr[63:0];
		qr   = udivmod(an * rm, 64'(rays));
		r    = an * q + qr[127:64];
		c    = series_q60(r, 1'b0);
		s    = series_q60(r, 1'b1);
		if (n[63])
			s = 64'd0 - s;
		unique case (quad[1:0])
			2'd0: begin
				cx = c;
				sy = s;
			end
			2'd1: begin
				cx = 64'd0 - s;
				sy = c;
			end
			2'd2: begin
				cx = 64'd0 - c;
				sy = 64'd0 - s;
			end
			default: begin
				cx = s;
				sy = 64'd0 - c;
			end
		endcase
		return {round_frac(cx, frac), round_frac(sy, frac)};
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/rmco_queue.sv
// Small synchronous FIFO in flip-flops with full and empty decoded from a registered count.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rmco_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok)
				wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop_ok)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			cnt_q <= cnt_q + CW'(push_ok) - CW'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			mem_q[wr_ptr_q] <= wr_data;
	end

	`ASSERT_RST(a_cnt_bound, clk, arst_n, cnt_q <= CW'(DEPTH))
	`ASSERT_RST(a_ptr_cnt, clk, arst_n, (wr_ptr_q - rd_ptr_q) == cnt_q[AW-1:0])
	`ASSERT_RST(a_no_overrun, clk, arst_n, (push && full && !pop) |=> $stable(cnt_q))

endmodule

`default_nettype wire

// File: rtl/core/rmco_front.sv
// Front end: configuration registers and classification of incoming commands.
`timescale 1ns / 1ps
`default_nettype none

module rmco_front import rmco_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	input  logic                 command,
	input  logic [IDX_W-1:0]     ray_index,
	output mq_entry_t            entry,
	output cfg_t                 cfg
);

	cfg_t cfg_q;
	logic cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_x         <= LIGHT_X_RST;
			cfg_q.light_y         <= LIGHT_Y_RST;
			cfg_q.obstacle_x      <= OBS_X_RST;
			cfg_q.obstacle_y      <= OBS_Y_RST;
			cfg_q.obstacle_radius <= OBS_R_RST;
			cfg_q.screen_width    <= SCREEN_W_RST;
			cfg_q.screen_height   <= SCREEN_H_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LIGHT_X:  cfg_q.light_x         <= cfg_data;
				REG_LIGHT_Y:  cfg_q.light_y         <= cfg_data;
				REG_OBS_X:    cfg_q.obstacle_x      <= cfg_data;
				REG_OBS_Y:    cfg_q.obstacle_y      <= cfg_data;
				REG_OBS_R:    cfg_q.obstacle_radius <= cfg_data[RAD_W-1:0];
				REG_SCREEN_W: cfg_q.screen_width    <= cfg_data;
				REG_SCREEN_H: cfg_q.screen_height   <= cfg_data;
				default: ;
			endcase
		end
	end

	// A start takes the light position along with it; a step carries its kind and index.
	always_comb begin
		entry.cmd       = cmd_t'(command);
		entry.ray_index = ray_index;
		if (cmd_t'(command) == CMD_START) begin
			entry.light_x = cfg_q.light_x;
			entry.light_y = cfg_q.light_y;
		end else begin
			entry.light_x = '0;
			entry.light_y = '0;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rmco_back.sv
// Back end: marching position, distance squares, obstacle and screen tests, result build.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rmco_back import rmco_pkg::*; #(
	parameter int RAYS      = 128,
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  mq_entry_t head,
	input  logic      mq_empty,
	output logic      mq_pop,
	input  cfg_t      cfg,
	output result_t   res,
	output logic      oq_push,
	input  logic      oq_full
);

	localparam int DW    = FRAC_BITS + 2;
	localparam int PW    = FRAC_BITS + COORD_W + 2;
	localparam int AW    = FRAC_BITS + COORD_W + 1;
	localparam int SQW   = 2 * AW;
	localparam int RSW   = 2 * RAD_W;
	localparam int TAB_N = 2 ** IDX_W;

	logic signed [DW-1:0] tab_x [TAB_N];
	logic signed [DW-1:0] tab_y [TAB_N];

	for (genvar g = 0; g < TAB_N; g++) begin : g_tab
		localparam logic [127:0] Dir = ray_dir(RAYS, FRAC_BITS, g);
		assign tab_x[g] = Dir[64 +: DW];
		assign tab_y[g] = Dir[0 +: DW];
	end

	logic                 en;
	logic                 fire;
	logic signed [PW-1:0] pos_x_q;
	logic signed [PW-1:0] pos_y_q;
	logic signed [DW-1:0] dir_x_q;
	logic signed [DW-1:0] dir_y_q;
	logic                 v_s1;
	logic                 v_s2;
	logic                 v_s3;
	cmd_t                 cmd_s1;
	cmd_t                 cmd_s2;
	cmd_t                 cmd_s3;
	logic [AW-1:0]        dx_s2;
	logic [AW-1:0]        dy_s2;
	logic                 off_s2;
	logic                 off_s3;
	logic [COORD_W-1:0]   px_s2;
	logic [COORD_W-1:0]   py_s2;
	logic [COORD_W-1:0]   px_s3;
	logic [COORD_W-1:0]   py_s3;
	logic [SQW-1:0]       sqx_s3;
	logic [SQW-1:0]       sqy_s3;
	logic [RSW-1:0]       rsq_q;
	logic                 active_q;
	logic [PW-1:0]        mag_x;
	logic [PW-1:0]        mag_y;
	logic                 off_c;
	logic [SQW:0]         sum_sq;
	logic [SQW:0]         rad_sq;
	logic                 hit;

	function automatic logic [COORD_W-1:0] trunc_pix(input logic signed [PW-1:0] p);
		logic [PW-1:0]      m;
		logic [COORD_W-1:0] t;
		m = p[PW-1] ? (PW'(0) - p) : p;
		t = m[FRAC_BITS +: COORD_W];
		return p[PW-1] ? (COORD_W'(0) - t) : t;
	endfunction

	function automatic logic [PW-1:0] abs_diff(input logic signed [PW-1:0] p,
			input logic [COORD_W-1:0] c);
		logic signed [PW-1:0] d;
		d = p - $signed({2'b00, c, {FRAC_BITS{1'b0}}});
		return d[PW-1] ? (PW'(0) - d) : d;
	endfunction

	// The whole pipeline moves together; it holds only when a finished result cannot leave.
	assign en      = !(v_s3 && oq_full);
	assign fire    = en && !mq_empty;
	assign mq_pop  = fire;
	assign oq_push = v_s3 && !oq_full;

	// Stage one: the ray state itself. A start reloads it, a step adds the direction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			dir_x_q <= '0;
			dir_y_q <= '0;
		end else if (fire) begin
			if (head.cmd == CMD_START) begin
				pos_x_q <= $signed({2'b00, head.light_x, {FRAC_BITS{1'b0}}});
				pos_y_q <= $signed({2'b00, head.light_y, {FRAC_BITS{1'b0}}});
				dir_x_q <= tab_x[head.ray_index];
				dir_y_q <= tab_y[head.ray_index];
			end else begin
				pos_x_q <= pos_x_q + {{(PW-DW){dir_x_q[DW-1]}}, dir_x_q};
				pos_y_q <= pos_y_q + {{(PW-DW){dir_y_q[DW-1]}}, dir_y_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		mag_x = abs_diff(pos_x_q, cfg.obstacle_x);
		mag_y = abs_diff(pos_y_q, cfg.obstacle_y);
		off_c = pos_x_q[PW-1] || pos_y_q[PW-1]
			|| (pos_x_q > $signed({2'b00, cfg.screen_width, {FRAC_BITS{1'b0}}}))
			|| (pos_y_q > $signed({2'b00, cfg.screen_height, {FRAC_BITS{1'b0}}}));
	end

	always_ff @(posedge clk) begin
		rsq_q <= cfg.obstacle_radius * cfg.obstacle_radius;
		if (en) begin
			cmd_s1 <= head.cmd;
			cmd_s2 <= cmd_s1;
			dx_s2  <= mag_x[AW-1:0];
			dy_s2  <= mag_y[AW-1:0];
			off_s2 <= off_c;
			px_s2  <= trunc_pix(pos_x_q);
			py_s2  <= trunc_pix(pos_y_q);
			cmd_s3 <= cmd_s2;
			sqx_s3 <= dx_s2 * dx_s2;
			sqy_s3 <= dy_s2 * dy_s2;
			off_s3 <= off_s2;
			px_s3  <= px_s2;
			py_s3  <= py_s2;
		end
	end

	// Stage three output: strictly inside the circle when the squared distance is below r^2.
	always_comb begin
		sum_sq = {1'b0, sqx_s3} + {1'b0, sqy_s3};
		rad_sq = {{(SQW + 1 - RSW - 2 * FRAC_BITS){1'b0}}, rsq_q, {(2 * FRAC_BITS){1'b0}}};
		hit    = sum_sq < rad_sq;
	end

	always_comb begin
		res = '0;
		if (cmd_s3 == CMD_STEP) begin
			if (active_q) begin
				res.pixel_valid  = 1'b1;
				res.x_pixel      = px_s3;
				res.y_pixel      = py_s3;
				res.ray_done     = hit || off_s3;
				res.hit_obstacle = hit;
			end else begin
				res.ray_done = 1'b1;
			end
		end
	end

	// The ray is known to be alive only here, so steps that followed a final one
	// come out as idle steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (oq_push) begin
			if (cmd_s3 == CMD_START)
				active_q <= 1'b1;
			else if (res.ray_done)
				active_q <= 1'b0;
		end
	end

	`ASSERT_RST(a_hit_ends_ray, clk, arst_n, (oq_push && res.hit_obstacle) |=> !active_q)
	`ASSERT_RST(a_idle_fields, clk, arst_n, (oq_push && !res.pixel_valid) |-> (res.x_pixel == '0 && res.y_pixel == '0 && !res.hit_obstacle))
	`ASSERT_RST(a_stall_holds, clk, arst_n, !en |=> (v_s3 && $stable(sqx_s3) && $stable(px_s3)))

endmodule

`default_nettype wire

// File: rtl/core/ray_march_circle_occlusion.sv
// Top level of the 2D light ray marcher with one circular obstacle.
//
// Input side is a queue: an item (command, ray_index) is taken at a clock edge with
// push high and full low. A start command loads the light position and the unit
// direction of the chosen angle; a step command advances the ray by one direction
// vector. Every item gives exactly one result.
// Result side is also a queue: while empty is low the oldest result sits on
// pixel_valid, x_pixel, y_pixel, ray_done and hit_obstacle, and it leaves at an edge
// with pop high. A step ends the ray when it lands strictly inside the circle or
// outside the screen; steps with no live ray come back with only ray_done set.
// Configuration writes use cfg_valid/cfg_ready (always ready) with cfg_index and
// cfg_data; the user must make them only while no item is in flight, which the
// block does not enforce. Throughput is one item per cycle while the result queue
// has room, set by the position add that feeds back on itself.
// If pop stays low, up to four results wait in the result queue, three more sit in
// the pipeline and two in the command queue before full rises; nothing is lost.
// Reset clears both queues, returns the configuration registers to their defaults
// and leaves no ray active; the block can take items as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module ray_march_circle_occlusion import rmco_pkg::*; #(
	parameter int RAYS      = 128,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 command,
	input  logic [IDX_W-1:0]     ray_index,
	output logic                 empty,
	input  logic                 pop,
	output logic                 pixel_valid,
	output logic [COORD_W-1:0]   x_pixel,
	output logic [COORD_W-1:0]   y_pixel,
	output logic                 ray_done,
	output logic                 hit_obstacle,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);

	localparam int MQ_W = $bits(mq_entry_t);
	localparam int OQ_W = $bits(result_t);

	mq_entry_t       entry;
	mq_entry_t       mq_head;
	logic [MQ_W-1:0] mq_head_bits;
	logic            mq_empty;
	logic            mq_pop;
	cfg_t            cfg;
	result_t         res;
	result_t         oq_head;
	logic [OQ_W-1:0] oq_head_bits;
	logic            oq_push;
	logic            oq_full;

	rmco_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.command   (command),
		.ray_index (ray_index),
		.entry     (entry),
		.cfg       (cfg)
	);

	// Commands wait here so that the front can keep taking items while the back stalls.
	rmco_queue #(
		.WIDTH (MQ_W),
		.DEPTH (MQ_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (MQ_W'(entry)),
		.full    (full),
		.pop     (mq_pop),
		.rd_data (mq_head_bits),
		.empty   (mq_empty)
	);

	assign mq_head = mq_entry_t'(mq_head_bits);

	rmco_back #(
		.RAYS      (RAYS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (mq_head),
		.mq_empty (mq_empty),
		.mq_pop   (mq_pop),
		.cfg      (cfg),
		.res      (res),
		.oq_push  (oq_push),
		.oq_full  (oq_full)
	);

	// Finished results; this register stage parts the consumer from the pipeline.
	rmco_queue #(
		.WIDTH (OQ_W),
		.DEPTH (OQ_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (oq_push),
		.wr_data (OQ_W'(res)),
		.full    (oq_full),
		.pop     (pop),
		.rd_data (oq_head_bits),
		.empty   (empty)
	);

	assign oq_head      = result_t'(oq_head_bits);
	assign pixel_valid  = oq_head.pixel_valid;
	assign x_pixel      = oq_head.x_pixel;
	assign y_pixel      = oq_head.y_pixel;
	assign ray_done     = oq_head.ray_done;
	assign hit_obstacle = oq_head.hit_obstacle;

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the ray marcher with one circular obstacle.
`timescale 1ns / 1ps

// Tracks light rays the way the block should: own register copies, own ray state
// and a queue of the pixels that the block still owes.
class ray_march_tracker;
	localparam int NUM_RAYS   = 128;
	localparam int FRAC       = 16;
	localparam int ANGLE_FRAC = 60;
	localparam longint unsigned ANGLE_ONE    = 64'h1000_0000_0000_0000;
	localparam longint unsigned QUARTER_TURN = 64'h1921_FB54_442D_1846;

	longint light_x, light_y, obstacle_x, obstacle_y, radius, screen_w, screen_h;
	longint pos_x, pos_y, dir_x, dir_y;
	bit     ray_active;
	longint cos_table[NUM_RAYS];
	longint sin_table[NUM_RAYS];
	rmco_pkg::result_t pending_pixels[$];
	int errors, results_checked, hits, exits, dead_steps;

	function new();
		light_x    = rmco_pkg::LIGHT_X_RST;
		light_y    = rmco_pkg::LIGHT_Y_RST;
		obstacle_x = rmco_pkg::OBS_X_RST;
		obstacle_y = rmco_pkg::OBS_Y_RST;
		radius     = rmco_pkg::OBS_R_RST;
		screen_w   = rmco_pkg::SCREEN_W_RST;
		screen_h   = rmco_pkg::SCREEN_H_RST;
		pos_x      = 0;
		pos_y      = 0;
		dir_x      = 0;
		dir_y      = 0;
		ray_active = 0;
		for (int i = 0; i < NUM_RAYS; i++)
			build_direction(i);
	endfunction

	function longint unsigned q60_product(longint unsigned a, longint unsigned b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Cos or sin of an angle of at most a quarter of pi, both in Q60.
	function longint taylor(longint unsigned x, bit want_sin);
		longint unsigned x2, term, dv;
		longint          sum;
		x2   = q60_product(x, x);
		term = want_sin ? x : ANGLE_ONE;
		sum  = longint'(term);
		for (int k = 2; k < 64 && term != 0; k += 2) begin
			dv   = want_sin ? k * (k + 1) : (k - 1) * k;
			term = q60_product(term, x2) / dv;
			if ((k / 2) % 2 == 1)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		return sum;
	endfunction

	// Round half away from zero from Q60 down to the pixel fraction.
	function longint to_frac(longint v);
		longint unsigned m, r;
		m = v < 0 ? -v : v;
		r = (m + (64'd1 << (ANGLE_FRAC - FRAC - 1))) >> (ANGLE_FRAC - FRAC);
		return v < 0 ? -longint'(r) : longint'(r);
	endfunction

	// The angle is folded to the nearest axis, then the quadrant swaps and negates.
	function void build_direction(int index);
		longint          idx, quad, n, c, s, cx, sy;
		longint unsigned an, q, rm, ang;
		idx  = index % NUM_RAYS;
		quad = (8 * idx + NUM_RAYS) / (2 * NUM_RAYS);
		n    = 4 * idx - quad * NUM_RAYS;
		an   = n < 0 ? -n : n;
		q    = QUARTER_TURN / NUM_RAYS;
		rm   = QUARTER_TURN % NUM_RAYS;
		ang  = an * q + (an * rm) / NUM_RAYS;
		c    = taylor(ang, 1'b0);
		s    = taylor(ang, 1'b1);
		if (n < 0)
			s = -s;
		case (quad % 4)
			0: begin
				cx = c;
				sy = s;
			end
			1: begin
				cx = -s;
				sy = c;
			end
			2: begin
				cx = -c;
				sy = -s;
			end
			default: begin
				cx = s;
				sy = -c;
			end
		endcase
		cos_table[index] = to_frac(cx);
		sin_table[index] = to_frac(sy);
	endfunction

	function void set_register(rmco_pkg::reg_idx_t which, longint unsigned value);
		case (which)
			rmco_pkg::REG_LIGHT_X:  light_x    = value & 12'hFFF;
			rmco_pkg::REG_LIGHT_Y:  light_y    = value & 12'hFFF;
			rmco_pkg::REG_OBS_X:    obstacle_x = value & 12'hFFF;
			rmco_pkg::REG_OBS_Y:    obstacle_y = value & 12'hFFF;
			rmco_pkg::REG_OBS_R:    radius     = value & 11'h7FF;
			rmco_pkg::REG_SCREEN_W: screen_w   = value & 12'hFFF;
			rmco_pkg::REG_SCREEN_H: screen_h   = value & 12'hFFF;
			default: ;
		endcase
	endfunction

	function logic [11:0] to_pixel(longint p);
		longint t;
		t = p < 0 ? -((-p) >>> FRAC) : (p >>> FRAC);
		return 12'(t);
	endfunction

	function bit strictly_inside();
		longint       ddx, ddy;
		logic [63:0]  dx, dy;
		logic [129:0] dist2, lim2;
		ddx   = pos_x - (obstacle_x <<< FRAC);
		ddy   = pos_y - (obstacle_y <<< FRAC);
		dx    = ddx < 0 ? -ddx : ddx;
		dy    = ddy < 0 ? -ddy : ddy;
		dist2 = {66'd0, dx} * {66'd0, dx} + {66'd0, dy} * {66'd0, dy};
		lim2  = (radius <<< FRAC) * (radius <<< FRAC);
		return dist2 < lim2;
	endfunction

	function void take_command(rmco_pkg::cmd_t cmd, logic [6:0] index);
		rmco_pkg::result_t want;
		bit                hit, off;
		want = '0;
		if (cmd == rmco_pkg::CMD_START) begin
			pos_x      = light_x <<< FRAC;
			pos_y      = light_y <<< FRAC;
			dir_x      = cos_table[index % NUM_RAYS];
			dir_y      = sin_table[index % NUM_RAYS];
			ray_active = 1;
		end else if (!ray_active) begin
			want.ray_done = 1'b1;
			dead_steps++;
		end else begin
			pos_x += dir_x;
			pos_y += dir_y;
			hit = strictly_inside();
			off = pos_x < 0 || pos_y < 0 ||
				pos_x > (screen_w <<< FRAC) || pos_y > (screen_h <<< FRAC);
			want.pixel_valid  = 1'b1;
			want.x_pixel      = to_pixel(pos_x);
			want.y_pixel      = to_pixel(pos_y);
			want.ray_done     = hit || off;
			want.hit_obstacle = hit;
			if (hit)
				hits++;
			else if (off)
				exits++;
			if (hit || off)
				ray_active = 0;
		end
		pending_pixels.push_back(want);
	endfunction

	function void compare_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endfunction

	function void match_result(rmco_pkg::result_t got);
		rmco_pkg::result_t want;
		if (pending_pixels.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d/%0d",
				$time, got.pixel_valid, got.x_pixel, got.y_pixel, got.ray_done,
				got.hit_obstacle);
		end else begin
			want = pending_pixels.pop_front();
			results_checked++;
			compare_field("pixel_valid", want.pixel_valid, got.pixel_valid);
			compare_field("x_pixel", want.x_pixel, got.x_pixel);
			compare_field("y_pixel", want.y_pixel, got.y_pixel);
			compare_field("ray_done", want.ray_done, got.ray_done);
			compare_field("hit_obstacle", want.hit_obstacle, got.hit_obstacle);
		end
	endfunction
endclass

module testbench;
	import rmco_pkg::*;

	// Cycles without any handshake before the run is declared hung. The slowest
	// correct run stalls a receiver at 86 percent, so even long random stalls stay
	// far below this.
	localparam int WATCHDOG_LIMIT = 3000;
	// Cycles to wait after the last owed result before the block counts as idle.
	localparam int SETTLE_CYCLES  = 16;
	localparam int PHASE_ITEMS    = 166;
	localparam int NUM_PHASES     = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic                 command;
	logic [IDX_W-1:0]     ray_index;
	logic                 empty;
	logic                 pop;
	logic                 pixel_valid;
	logic [COORD_W-1:0]   x_pixel;
	logic [COORD_W-1:0]   y_pixel;
	logic                 ray_done;
	logic                 hit_obstacle;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;

	result_t          result_seen;
	ray_march_tracker tracker;
	int               send_idle_pct;
	int               recv_stall_pct;
	int               stuck_cycles;
	int               items_sent;
	int               settings_applied;

	ray_march_circle_occlusion dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.ray_index    (ray_index),
		.empty        (empty),
		.pop          (pop),
		.pixel_valid  (pixel_valid),
		.x_pixel      (x_pixel),
		.y_pixel      (y_pixel),
		.ray_done     (ray_done),
		.hit_obstacle (hit_obstacle),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	assign result_seen = {pixel_valid, x_pixel, y_pixel, ray_done, hit_obstacle};

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Result side. Pop is redrawn every cycle from the current stall rate, and the
	// result is checked at the edge where it leaves, using the values that held just
	// before that edge.
	always @(posedge clk) begin
		pop <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
		if (arst_n && pop && !empty)
			tracker.match_result(result_seen);
	end

	// Watchdog: any item, result or register write that moves resets the count.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else if (stuck_cycles < WATCHDOG_LIMIT)
			stuck_cycles <= stuck_cycles + 1;
		else begin
			$display("%0t: nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Every driving task starts and ends right after a rising edge. Push is left
	// high after an item is taken so that back-to-back items need no second
	// assignment in the same step; a gap lowers it first.
	task automatic send_item(input cmd_t cmd, input logic [IDX_W-1:0] index);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		command   <= cmd;
		ray_index <= index;
		do
			@(posedge clk);
		while (full);
		tracker.take_command(cmd, index);
		items_sent++;
	endtask

	task automatic write_register(input reg_idx_t which, input logic [COORD_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.set_register(which, value);
	endtask

	// Stops the input side and lets every owed result drain, then waits SETTLE_CYCLES
	// more so that nothing is still in the pipeline.
	task automatic wait_idle();
		push <= 1'b0;
		while (tracker.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Registers change only with the block drained.
	task automatic apply_settings(input logic [COORD_W-1:0] lx, input logic [COORD_W-1:0] ly,
		input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
		input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] w,
		input logic [COORD_W-1:0] h);
		wait_idle();
		write_register(REG_LIGHT_X, lx);
		write_register(REG_LIGHT_Y, ly);
		write_register(REG_OBS_X, ox);
		write_register(REG_OBS_Y, oy);
		write_register(REG_OBS_R, r);
		write_register(REG_SCREEN_W, w);
		write_register(REG_SCREEN_H, h);
		cfg_valid <= 1'b0;
		@(posedge clk);
		settings_applied++;
	endtask

	initial begin
		int phase;
		int phase_end;
		int k;
		int cap;
		int w;
		int h;
		tracker          = new();
		arst_n           = 1'b0;
		push             = 1'b0;
		command          = 1'b0;
		ray_index        = '0;
		pop              = 1'b0;
		cfg_valid        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		stuck_cycles     = 0;
		items_sent       = 0;
		settings_applied = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first with the reset settings. A step with no ray comes
		// back with only ray_done; a start while a ray is live drops the old one.
		send_item(CMD_STEP, 7'h7F);
		send_item(CMD_START, 7'd0);
		send_item(CMD_STEP, 7'd0);
		send_item(CMD_STEP, 7'd0);
		send_item(CMD_START, 7'd32);
		send_item(CMD_STEP, 7'd0);
		send_item(CMD_START, 7'd127);
		send_item(CMD_STEP, 7'd0);
		send_item(CMD_STEP, 7'd0);

		// A ray along +x toward a small circle: the step at exactly the radius is
		// not inside, the next one hits; then a step after the ray has ended.
		apply_settings(12'd10, 12'd10, 12'd14, 12'd10, 12'd2, 12'd30, 12'd30);
		send_item(CMD_START, 7'd0);
		send_item(CMD_STEP, 7'd0);
		send_item(CMD_STEP, 7'd0);
		send_item(CMD_STEP, 7'd0);
		send_item(CMD_STEP, 7'd0);

		// Light at the origin heading to -x: the pixel goes negative (sent as all
		// ones) and the same step both leaves the screen and lands in the circle.
		apply_settings(12'd0, 12'd0, 12'd0, 12'd0, 12'd5, 12'd4094, 12'd4094);
		send_item(CMD_START, 7'd64);
		send_item(CMD_STEP, 7'd0);

		// Zero radius, light at the far corner: x wraps past 4095 in the pixel.
		apply_settings(12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd4094, 12'd4094);
		send_item(CMD_START, 7'd0);
		send_item(CMD_STEP, 7'd0);
		send_item(CMD_START, 7'd96);
		send_item(CMD_STEP, 7'd0);

		// Largest radius, starting at its centre.
		apply_settings(12'd2047, 12'd2047, 12'd2047, 12'd2047, 12'd2047, 12'd4094, 12'd4094);
		send_item(CMD_START, 7'd16);
		send_item(CMD_STEP, 7'd0);

		// Random part. Each phase draws its settings (small screens keep rays short,
		// a few phases use the extremes) and one of four idling patterns. Most items
		// form rays: a start, steps until the ray ends or a cap, sometimes a step
		// past the end. One sequence in ten is a single random item instead.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				2: apply_settings(12'd0, 12'd2030, 12'd2047, 12'd2047, 12'd2047,
					12'd4094, 12'd4094);
				5: apply_settings(12'd1, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd1, 12'd1);
				7: apply_settings(12'd4095, 12'd4095, 12'd4000, 12'd4000, 12'd140,
					12'd4094, 12'd4094);
				default: begin
					w = $urandom_range(4, 60);
					h = $urandom_range(4, 60);
					apply_settings(12'($urandom_range(0, w)), 12'($urandom_range(0, h)),
						12'($urandom_range(0, w + 10)), 12'($urandom_range(0, h + 10)),
						12'($urandom_range(0, 15)), 12'(w), 12'(h));
				end
			endcase
			case (phase % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct  = 86;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct <= 86;
				end
				default: begin
					send_idle_pct  = 18;
					recv_stall_pct <= 18;
				end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(cmd_t'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
				end else begin
					send_item(CMD_START, 7'($urandom_range(0, 127)));
					cap = $urandom_range(1, 40);
					for (k = 0; k < cap && tracker.ray_active && items_sent < phase_end; k++)
						send_item(CMD_STEP, 7'($urandom_range(0, 127)));
					if ($urandom_range(0, 3) == 0 && items_sent < phase_end)
						send_item(CMD_STEP, 7'($urandom_range(0, 127)));
				end
			end
		end

		wait_idle();
		$display("Ran %0d items under %0d register settings; %0d results checked.",
			items_sent, settings_applied, tracker.results_checked);
		$display("Rays ended %0d times in the obstacle and %0d off screen; %0d dead steps.",
			tracker.hits, tracker.exits, tracker.dead_steps);
		if (tracker.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
